FILE: design/wsp_pkg.sv
// Shared types and constants for the RIFF/WAVE byte stream parser.
// No dependencies; wsp_dp, wsp_ctrl and wav_stream_parser import this package.
package wsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] RATE_44K1 = 32'd44100;
  localparam logic [31:0] RATE_48K  = 32'd48000;
  localparam logic [31:0] RATE_96K  = 32'd96000;
  localparam logic [31:0] RATE_192K = 32'd192000;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_SIZE  = 16'd16;
  // frames*channels*4 may not exceed 2^30: frame limit plus one, per channel count
  localparam logic [28:0] FRAMES_LIM_MONO   = 29'h1000_0001;
  localparam logic [28:0] FRAMES_LIM_STEREO = 29'h0800_0001;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_RIFF_TAG   = 4'd0,
    ERR_WAVE_TAG   = 4'd1,
    ERR_SIZE       = 4'd2,
    ERR_SHORT_HDR  = 4'd3,
    ERR_OVERRUN    = 4'd4,
    ERR_FMT_PLACE  = 4'd5,
    ERR_FORMAT     = 4'd6,
    ERR_ALIGN_RATE = 4'd7,
    ERR_DATA_PLACE = 4'd8,
    ERR_FRAMES     = 4'd9,
    ERR_TOO_LARGE  = 4'd10,
    ERR_MISSING    = 4'd11
  } err_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RIFF,
    OP_SIZE,
    OP_WAVE,
    OP_HDR,
    OP_FMT,
    OP_DATA,
    OP_SKIP
  } op_t;

  // chunk id codes kept during a header
  localparam logic [1:0] CID_OTHER = 2'd0;
  localparam logic [1:0] CID_FMT   = 2'd1;
  localparam logic [1:0] CID_DATA  = 2'd2;

  typedef struct packed {
    logic   take;
    op_t    op;
    logic   pad_op;
    logic   restart;
    logic   res_load;
    kind_t  res_kind;
    err_t   res_err;
    logic   carry;
  } wsp_cmd_t;

  typedef struct packed {
    logic  err_v;
    err_t  err_code;
    logic  word_done;
    logic  go_fmt;
    logic  go_data;
    logic  go_skip;
    logic  chunk_end;
    logic  pad;
    logic  fmt_ok;
    logic  smp_v;
    logic  pos_end;
    logic  seen_both;
  } wsp_stat_t;

  // zero test of a 32-bit value modulo 3 (2^8 and 2^2 are 1 mod 3)
  function automatic logic mod3_zero(input logic [31:0] a);
    logic [9:0] s;
    logic [3:0] t;
    s = 10'(a[7:0]) + 10'(a[15:8]) + 10'(a[23:16]) + 10'(a[31:24]);
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]) + 4'(s[7:6]) + 4'(s[9:8]);
    return (t == 4'd0) || (t == 4'd3) || (t == 4'd6) || (t == 4'd9) ||
           (t == 4'd12) || (t == 4'd15);
  endfunction

endpackage

FILE: design/wsp_if.sv
// Valid/ready channel interfaces for file bytes and parser results.
// Depends on nothing.
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;
  modport source (output valid, in_byte, end_of_file, input ready);
  modport sink   (input valid, in_byte, end_of_file, output ready);
endinterface

interface wsp_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  result_kind;
  logic signed [23:0] sample;
  logic               channel;
  logic        [1:0]  channel_count;
  logic        [17:0] rate_hz;
  logic        [4:0]  sample_bits;
  logic        [3:0]  error_code;
  modport source (output valid, result_kind, sample, channel, channel_count, rate_hz,
                  sample_bits, error_code, input ready);
  modport sink   (input valid, result_kind, sample, channel, channel_count, rate_hz,
                  sample_bits, error_code, output ready);
endinterface

FILE: design/wsp_dp.sv
// Parser datapath: byte shifter, counters, format registers, checks, result register.
// Depends on wsp_pkg; driven by wsp_ctrl commands.
module wsp_dp
  import wsp_pkg::*;
(
  input  logic               clk,
  input  logic [7:0]         in_byte,
  input  wsp_cmd_t           cmd,
  output wsp_stat_t          stat,
  output logic        [1:0]  result_kind,
  output logic signed [23:0] sample,
  output logic               channel,
  output logic        [1:0]  channel_count,
  output logic        [17:0] rate_hz,
  output logic        [4:0]  sample_bits,
  output logic        [3:0]  error_code,
  input  logic               rst_n
);

  logic [4:0]  fbc_r, fbc_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] rr_r, rr_nxt;
  logic [31:0] cl_r, cl_nxt;
  logic        pad_r, pad_nxt;
  logic        seen_fmt_r, seen_fmt_nxt;
  logic        seen_data_r, seen_data_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [17:0] rate_r, rate_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [2:0]  align_r, align_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  sbi_r, sbi_nxt;
  logic        cur_r, cur_nxt;

  logic [31:0] sh;
  logic [15:0] v16;
  logic [32:0] padded;
  logic        rem_nz;
  logic [31:0] lim;
  logic [20:0] brate_chk;
  logic [3:0]  align_chk;
  logic [23:0] acc_in;
  logic [23:0] smp;
  logic [1:0]  bps;
  logic        smp_ch;
  wsp_stat_t   st;

  assign sh        = {in_byte, shift_r[31:8]};
  assign v16       = sh[31:16];
  assign padded    = {1'b0, sh} + 33'(sh[0]);
  assign lim       = 32'(align_r) * 32'((ch_r == 2'd2) ? FRAMES_LIM_STEREO : FRAMES_LIM_MONO);
  assign brate_chk = 21'(rate_r) * 21'(align_r);
  assign align_chk = 4'(ch_r) * 4'(v16[4:3]);
  assign bps       = (bits_r == 5'd16) ? 2'd2 : 2'd3;
  assign acc_in    = (acc_r | (24'(in_byte) << {sbi_r, 3'b000}));

  always_comb begin
    case (align_r)
      3'd1:    rem_nz = 1'b0;
      3'd2:    rem_nz = sh[0];
      3'd3:    rem_nz = !mod3_zero(sh);
      3'd4:    rem_nz = |sh[1:0];
      3'd6:    rem_nz = sh[0] || !mod3_zero(sh);
      default: rem_nz = 1'b1;
    endcase
  end

  always_comb begin
    fbc_nxt = fbc_r;  shift_nxt = shift_r;  rr_nxt = rr_r;  cl_nxt = cl_r;
    pad_nxt = pad_r;  seen_fmt_nxt = seen_fmt_r;  seen_data_nxt = seen_data_r;
    ch_nxt = ch_r;  rate_nxt = rate_r;  bits_nxt = bits_r;  align_nxt = align_r;
    brate_nxt = brate_r;  acc_nxt = acc_r;  sbi_nxt = sbi_r;  cur_nxt = cur_r;
    st = '0;
    st.err_code = ERR_RIFF_TAG;
    smp = '0;
    smp_ch = 1'b0;
    if (cmd.pad_op) begin
      rr_nxt  = rr_r - 32'd1;
      pad_nxt = 1'b0;
    end else begin
      case (cmd.op)
        OP_RIFF, OP_SIZE, OP_WAVE: begin
          shift_nxt = sh;
          fbc_nxt   = fbc_r + 5'd1;
          if (fbc_r == 5'd3) begin
            fbc_nxt = '0;
            st.word_done = 1'b1;
            if (cmd.op == OP_RIFF && sh != TAG_RIFF) begin
              st.err_v = 1'b1;  st.err_code = ERR_RIFF_TAG;
            end else if (cmd.op == OP_WAVE && sh != TAG_WAVE) begin
              st.err_v = 1'b1;  st.err_code = ERR_WAVE_TAG;
            end else if (cmd.op == OP_SIZE) begin
              if (sh < 32'd4) begin
                st.err_v = 1'b1;  st.err_code = ERR_SIZE;
              end else begin
                rr_nxt = sh - 32'd4;
              end
            end
          end
        end
        OP_HDR: begin
          if (fbc_r == '0 && rr_r == '0) begin
            st.err_v = 1'b1;  st.err_code = ERR_SIZE;
          end else if (fbc_r == '0 && rr_r < 32'd8) begin
            st.err_v = 1'b1;  st.err_code = ERR_SHORT_HDR;
          end else begin
            rr_nxt    = rr_r - 32'd1;
            shift_nxt = sh;
            fbc_nxt   = fbc_r + 5'd1;
            if (fbc_r == 5'd3) begin
              cl_nxt = (sh == TAG_FMT) ? 32'(CID_FMT) :
                       (sh == TAG_DATA) ? 32'(CID_DATA) : 32'(CID_OTHER);
            end else if (fbc_r == 5'd7) begin
              fbc_nxt = '0;
              if (padded > {1'b0, rr_nxt}) begin
                st.err_v = 1'b1;  st.err_code = ERR_OVERRUN;
              end else begin
                pad_nxt = sh[0];
                if (cl_r[1:0] == CID_FMT) begin
                  if (seen_fmt_r || seen_data_r || sh != 32'(FMT_SIZE)) begin
                    st.err_v = 1'b1;  st.err_code = ERR_FMT_PLACE;
                  end else begin
                    st.go_fmt = 1'b1;
                  end
                end else if (cl_r[1:0] == CID_DATA) begin
                  if (!seen_fmt_r || seen_data_r || sh == '0) begin
                    st.err_v = 1'b1;  st.err_code = ERR_DATA_PLACE;
                  end else if (rem_nz) begin
                    st.err_v = 1'b1;  st.err_code = ERR_FRAMES;
                  end else if (sh >= lim) begin
                    st.err_v = 1'b1;  st.err_code = ERR_TOO_LARGE;
                  end else begin
                    cl_nxt  = sh;
                    acc_nxt = '0;
                    sbi_nxt = '0;
                    cur_nxt = 1'b0;
                    st.go_data = 1'b1;
                  end
                end else begin
                  cl_nxt = sh;
                  if (sh == '0) st.chunk_end = 1'b1;
                  else st.go_skip = 1'b1;
                end
              end
            end
          end
        end
        OP_FMT: begin
          rr_nxt    = rr_r - 32'd1;
          shift_nxt = sh;
          fbc_nxt   = fbc_r + 5'd1;
          case (fbc_r)
            5'd1: begin
              if (v16 != FMT_PCM) begin
                st.err_v = 1'b1;  st.err_code = ERR_FORMAT;
              end
            end
            5'd3: begin
              if (v16 != 16'd1 && v16 != 16'd2) begin
                st.err_v = 1'b1;  st.err_code = ERR_FORMAT;
              end else begin
                ch_nxt = v16[1:0];
              end
            end
            5'd7: begin
              if (sh != RATE_44K1 && sh != RATE_48K && sh != RATE_96K && sh != RATE_192K) begin
                st.err_v = 1'b1;  st.err_code = ERR_FORMAT;
              end else begin
                rate_nxt = sh[17:0];
              end
            end
            5'd11: brate_nxt = sh;
            5'd13: align_nxt = (v16 <= 16'd7) ? v16[2:0] : 3'd0;
            5'd15: begin
              fbc_nxt = '0;
              if (v16 != 16'd16 && v16 != 16'd24) begin
                st.err_v = 1'b1;  st.err_code = ERR_FORMAT;
              end else if ({1'b0, align_r} != align_chk || brate_r != 32'(brate_chk)) begin
                st.err_v = 1'b1;  st.err_code = ERR_ALIGN_RATE;
              end else begin
                bits_nxt     = v16[4:0];
                seen_fmt_nxt = 1'b1;
                st.fmt_ok    = 1'b1;
                st.chunk_end = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_DATA: begin
          rr_nxt  = rr_r - 32'd1;
          cl_nxt  = cl_r - 32'd1;
          acc_nxt = acc_in;
          sbi_nxt = sbi_r + 2'd1;
          if (sbi_r + 2'd1 >= bps) begin
            smp = (bps == 2'd2) ? {{8{acc_in[15]}}, acc_in[15:0]} : acc_in;
            smp_ch = cur_r;
            st.smp_v = 1'b1;
            if (ch_r == 2'd2) cur_nxt = !cur_r;
            acc_nxt = '0;
            sbi_nxt = '0;
          end
          if (cl_r == 32'd1) begin
            seen_data_nxt = 1'b1;
            st.chunk_end  = 1'b1;
          end
        end
        OP_SKIP: begin
          rr_nxt = rr_r - 32'd1;
          cl_nxt = cl_r - 32'd1;
          if (cl_r == 32'd1) st.chunk_end = 1'b1;
        end
        default: ;
      endcase
    end
    st.pad       = pad_nxt;
    st.pos_end   = (fbc_nxt == '0) && (rr_nxt == '0);
    st.seen_both = seen_fmt_nxt && seen_data_nxt;
  end

  assign stat = st;

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.take && cmd.restart)) begin
      fbc_r <= '0;  shift_r <= '0;  rr_r <= '0;  cl_r <= '0;  pad_r <= 1'b0;
      seen_fmt_r <= 1'b0;  seen_data_r <= 1'b0;  ch_r <= '0;  rate_r <= '0;
      bits_r <= '0;  align_r <= '0;  brate_r <= '0;  acc_r <= '0;  sbi_r <= '0;
      cur_r <= 1'b0;
    end else if (cmd.take) begin
      fbc_r <= fbc_nxt;  shift_r <= shift_nxt;  rr_r <= rr_nxt;  cl_r <= cl_nxt;
      pad_r <= pad_nxt;  seen_fmt_r <= seen_fmt_nxt;  seen_data_r <= seen_data_nxt;
      ch_r <= ch_nxt;  rate_r <= rate_nxt;  bits_r <= bits_nxt;  align_r <= align_nxt;
      brate_r <= brate_nxt;  acc_r <= acc_nxt;  sbi_r <= sbi_nxt;  cur_r <= cur_nxt;
    end
  end

  // result word register, loaded when the controller posts a result
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result_kind   <= cmd.res_kind;
      sample        <= '0;
      channel       <= 1'b0;
      channel_count <= '0;
      rate_hz       <= '0;
      sample_bits   <= '0;
      error_code    <= '0;
      case (cmd.res_kind)
        KIND_SAMPLE: begin
          sample  <= smp;
          channel <= smp_ch;
        end
        KIND_FORMAT: begin
          channel_count <= ch_nxt;
          rate_hz       <= rate_nxt;
          sample_bits   <= bits_nxt;
        end
        KIND_DONE: begin
          channel_count <= ch_nxt;
          rate_hz       <= rate_nxt;
          if (cmd.carry) begin
            sample      <= smp;
            channel     <= smp_ch;
            sample_bits <= bits_nxt;
          end
        end
        default: error_code <= cmd.res_err;
      endcase
    end
  end

endmodule

FILE: design/wsp_ctrl.sv
// Parser controller: file phase state machine, result posting, handshakes.
// Depends on wsp_pkg; commands wsp_dp and reads its status.
module wsp_ctrl
  import wsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      end_of_file,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output wsp_cmd_t  cmd,
  input  wsp_stat_t stat
);

  typedef enum logic [3:0] {
    P_RIFF, P_SIZE, P_WAVE, P_HDR, P_FMT, P_DATA, P_SKIP, P_PAD, P_FAIL
  } phase_t;

  phase_t phase_r, phase_nxt, adv;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    case (phase_r)
      P_RIFF:  cmd.op = OP_RIFF;
      P_SIZE:  cmd.op = OP_SIZE;
      P_WAVE:  cmd.op = OP_WAVE;
      P_HDR:   cmd.op = OP_HDR;
      P_FMT:   cmd.op = OP_FMT;
      P_DATA:  cmd.op = OP_DATA;
      P_SKIP:  cmd.op = OP_SKIP;
      default: cmd.op = OP_NONE;
    endcase
    cmd.take    = take;
    cmd.pad_op  = (phase_r == P_PAD);
    cmd.restart = end_of_file;

    // phase after this word, ignoring end of file
    adv = phase_r;
    case (phase_r)
      P_RIFF: if (stat.word_done) adv = P_SIZE;
      P_SIZE: if (stat.word_done) adv = P_WAVE;
      P_WAVE: if (stat.word_done) adv = P_HDR;
      P_PAD:  adv = P_HDR;
      default: begin
        if (stat.go_fmt) adv = P_FMT;
        else if (stat.go_data) adv = P_DATA;
        else if (stat.go_skip) adv = P_SKIP;
        else if (stat.chunk_end) adv = stat.pad ? P_PAD : P_HDR;
      end
    endcase
    if (stat.err_v) adv = P_FAIL;

    cmd.res_load = 1'b0;
    cmd.res_kind = KIND_SAMPLE;
    cmd.res_err  = ERR_RIFF_TAG;
    cmd.carry    = 1'b0;
    if (take && phase_r != P_FAIL) begin
      if (stat.err_v) begin
        cmd.res_load = 1'b1;
        cmd.res_kind = KIND_ERROR;
        cmd.res_err  = stat.err_code;
      end else if (end_of_file) begin
        cmd.res_load = 1'b1;
        if (!(adv == P_HDR && stat.pos_end)) begin
          cmd.res_kind = KIND_ERROR;
          cmd.res_err  = ERR_SIZE;
        end else if (!stat.seen_both) begin
          cmd.res_kind = KIND_ERROR;
          cmd.res_err  = ERR_MISSING;
        end else begin
          cmd.res_kind = KIND_DONE;
          cmd.carry    = stat.smp_v;
        end
      end else if (stat.smp_v) begin
        cmd.res_load = 1'b1;
        cmd.res_kind = KIND_SAMPLE;
      end else if (stat.fmt_ok) begin
        cmd.res_load = 1'b1;
        cmd.res_kind = KIND_FORMAT;
      end
    end

    phase_nxt = phase_r;
    if (take) phase_nxt = end_of_file ? P_RIFF : adv;

    out_valid_nxt = out_valid_r;
    if (cmd.res_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_RIFF;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/wav_stream_parser.sv
// Top level of the RIFF/WAVE PCM stream parser.
// Depends on wsp_pkg, wsp_if, wsp_ctrl and wsp_dp.
//
// Usage:
//   in_ch carries one file byte per word (in_byte) with end_of_file set on
//   the final byte. out_ch carries at most one result word per input byte:
//   a sample (sign-extended, tagged left/right), the accepted format, file
//   done, or a numbered error. Samples sent before an error are to be
//   discarded by the consumer.
//   Output: each result is registered and appears on out_ch in the cycle
//   after the byte that causes it is taken.
//   Throughput: one byte per cycle while in_ch.ready is high. All checks of
//   a byte, including the data-chunk frame checks (modulo by block align and
//   size limit), finish in the cycle the byte is taken.
//   Stall: the result register holds its word while out_ch.ready is low,
//   and in_ch.ready drops only while a result waits and the sink stalls.
//   Reset (rst_n low, synchronous) returns to expecting the RIFF tag with
//   no result pending. Any end_of_file byte also returns it to expecting the
//   RIFF tag; after an error, bytes are dropped until end_of_file.
module wav_stream_parser
  import wsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  wsp_in_if.sink    in_ch,
  wsp_out_if.source out_ch
);

  wsp_cmd_t  cmd;
  wsp_stat_t stat;

  wsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .end_of_file (in_ch.end_of_file),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  wsp_dp u_dp (
    .clk           (clk),
    .in_byte       (in_ch.in_byte),
    .cmd           (cmd),
    .stat          (stat),
    .result_kind   (out_ch.result_kind),
    .sample        (out_ch.sample),
    .channel       (out_ch.channel),
    .channel_count (out_ch.channel_count),
    .rate_hz       (out_ch.rate_hz),
    .sample_bits   (out_ch.sample_bits),
    .error_code    (out_ch.error_code),
    .rst_n         (rst_n)
  );

endmodule
